>>> design/float_round_and_minmax_unit_assert.svh
// Assertion macros for the float rounding and min/max unit
`ifndef FLOAT_ROUND_AND_MINMAX_UNIT_ASSERT_SVH
`define FLOAT_ROUND_AND_MINMAX_UNIT_ASSERT_SVH
`ifndef NO_ASSERTIONS
`define FRM_ASSERT_IMPL(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
`define FRM_ASSERT_ALWAYS(label, clk, prop, msg) \
    label: assert property (@(posedge clk) prop) else $error(msg);
`else
`define FRM_ASSERT_IMPL(label, clk, rst_n, prop, msg)
`define FRM_ASSERT_ALWAYS(label, clk, prop, msg)
`endif
`endif

>>> design/frm_pkg.sv
`default_nettype none
package frm_pkg;
    typedef enum logic [2:0] {
        OP_ABS   = 3'd0,
        OP_TRUNC = 3'd1,
        OP_FLOOR = 3'd2,
        OP_ROUND = 3'd3,
        OP_MIN   = 3'd4,
        OP_MAX   = 3'd5
    } t_action;

    localparam logic [31:0] SIGN_BIT = 32'h8000_0000;
    localparam logic [31:0] MAG_MASK = 32'h7fff_ffff;
    localparam logic [31:0] EXP_MASK = 32'h7f80_0000;
    localparam logic [31:0] ONE_BITS = 32'h3f80_0000;
    localparam logic [7:0]  BIAS     = 8'd127;
    localparam logic [7:0]  NO_FRAC  = 8'd150;
    localparam logic [7:0]  HALF_EXP = 8'd126;

    typedef struct packed {
        logic [2:0]  action;
        logic [31:0] first_operand;
        logic [31:0] second_operand;
    } t_req;

    function automatic logic f_is_nan(input logic [31:0] b);
        return (b & MAG_MASK) > EXP_MASK;
    endfunction
endpackage
`default_nettype wire

>>> design/frm_if.sv
`default_nettype none
interface frm_if #(parameter int W = 32) ();
    logic         valid;
    logic         ready;
    logic [W-1:0] data;
    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface
`default_nettype wire

>>> design/frm_round.sv
`default_nettype none
module frm_round import frm_pkg::*; (
    input  wire  [2:0]  i_action,
    input  wire  [31:0] i_a,
    output logic [31:0] o_r
);
    logic [7:0]  e;
    logic [4:0]  fb;
    logic [31:0] mask, unit, t, m, frac;

    always_comb begin
        e    = i_a[30:23];
        fb   = 5'(NO_FRAC - e);
        unit = 32'd1 << fb;
        mask = unit - 32'd1;
        t    = i_a;
        if (e < BIAS) t = i_a & SIGN_BIT;
        else if (e < NO_FRAC) t = i_a & ~mask;
        m = i_a & MAG_MASK & ~mask;
        frac = i_a & mask;
        o_r = i_a;
        case (t_action'(i_action))
            OP_ABS:   o_r = i_a & MAG_MASK;
            OP_TRUNC: o_r = t;
            OP_FLOOR: begin
                o_r = t;
                if (i_a[31] && (i_a & MAG_MASK) != 32'd0 && !f_is_nan(i_a) && t != i_a)
                    o_r = (e < BIAS) ? (SIGN_BIT | ONE_BITS) : t + unit;
            end
            OP_ROUND: begin
                if (e < HALF_EXP) o_r = i_a & SIGN_BIT;
                else if (e == HALF_EXP) o_r = (i_a & SIGN_BIT) | ONE_BITS;
                else if (e < NO_FRAC)
                    o_r = (i_a & SIGN_BIT) | (m + ((frac >= (unit >> 1)) ? unit : 32'd0));
            end
            default: o_r = i_a;
        endcase
    end
endmodule
`default_nettype wire

>>> design/frm_minmax.sv
`default_nettype none
module frm_minmax import frm_pkg::*; (
    input  wire         i_want_max,
    input  wire  [31:0] i_a,
    input  wire  [31:0] i_b,
    output logic [31:0] o_r
);
    logic [31:0] ka, kb;
    always_comb begin
        ka = i_a[31] ? ~i_a : (i_a | SIGN_BIT);
        kb = i_b[31] ? ~i_b : (i_b | SIGN_BIT);
        if (f_is_nan(i_a)) o_r = i_b;
        else if (f_is_nan(i_b)) o_r = i_a;
        else if (i_a == i_b || ((i_a & MAG_MASK) == 0 && (i_b & MAG_MASK) == 0))
            o_r = i_want_max ? (i_a & (i_b | MAG_MASK)) : (i_a | (i_b & SIGN_BIT));
        else if (i_want_max) o_r = (ka > kb) ? i_a : i_b;
        else o_r = (ka < kb) ? i_a : i_b;
    end
endmodule
`default_nettype wire

>>> design/float_round_and_minmax_unit.sv
// Float rounding and min/max unit.
// Each request is registered in the input register, and its result then in the result register,
// where it is held until it is taken; a stall can come between the two registers.
// Throughput: one request per cycle; the input stalls only when both registers are full
// and the result is not being taken.
// Reset: synchronous active-low i_rst_n clears the valid flags only.
`default_nettype none
`include "float_round_and_minmax_unit_assert.svh"
module float_round_and_minmax_unit import frm_pkg::*; (
    input wire i_clk,
    input wire i_rst_n,
    frm_if.sink   i_req,
    frm_if.source o_res
);
    t_req        r_req;
    logic        r_req_vld, r_res_vld;
    logic [31:0] r_res, n_res, w_round, w_mm;
    logic        w_adv;

    // advance the result stage when it is empty or being taken
    assign w_adv       = !r_res_vld || o_res.ready;
    assign i_req.ready = w_adv || !r_req_vld;
    assign o_res.valid = r_res_vld;
    assign o_res.data  = r_res;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_req_vld <= 1'b0;
            r_res_vld <= 1'b0;
        end else begin
            if (w_adv) r_res_vld <= r_req_vld;
            if (i_req.ready) r_req_vld <= i_req.valid;
        end
        if (i_req.ready && i_req.valid) r_req <= t_req'(i_req.data);
        if (w_adv && r_req_vld) r_res <= n_res;
    end

    frm_round u_round (.i_action(r_req.action), .i_a(r_req.first_operand), .o_r(w_round));
    frm_minmax u_mm (.i_want_max(r_req.action == OP_MAX), .i_a(r_req.first_operand),
                     .i_b(r_req.second_operand), .o_r(w_mm));

    // select min/max path for its codes, rounding path otherwise
    assign n_res = (r_req.action == OP_MIN || r_req.action == OP_MAX) ? w_mm : w_round;

    `FRM_ASSERT_IMPL(a_hold, i_clk, i_rst_n, r_res_vld && !o_res.ready |=> r_res_vld && $stable(r_res), "result dropped")
    `FRM_ASSERT_IMPL(a_move, i_clk, i_rst_n, r_req_vld && w_adv |=> r_res_vld, "request lost")
    `FRM_ASSERT_ALWAYS(a_rst, i_clk, !i_rst_n |=> !r_res_vld && !r_req_vld, "reset failed")
endmodule
`default_nettype wire
